/* rtl/core/interval_prime_finder_unit_assert.svh */
// Assertion macros for the interval prime finder.
`ifndef INTERVAL_PRIME_FINDER_UNIT_ASSERT_SVH
`define INTERVAL_PRIME_FINDER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define IPF_ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ipf assertion failed");
`define IPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipf assertion failed");
`else
`define IPF_ASSERT_HOLDS(lbl, clk, rst, prop)
`define IPF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/ipf_pkg.sv */
// Types and constants shared by the interval prime finder modules.
`timescale 1ns / 1ps
`default_nettype none
package ipf_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    KIND_PRIME = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_WRONG = 2'd2,
    KIND_SPAN  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [VALUE_W-1:0] low_bound;
    logic [VALUE_W-1:0] high_bound;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] prime_value;
    kind_t              kind;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_ADVANCE,
    S_PUSH_PRIME,
    S_PUSH_LAST
  } ipf_state_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic done;
    logic rem_zero;
    logic quot_below;
  } div_stat_t;

endpackage
`default_nettype wire

/* rtl/core/ipf_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ipf_serial_div
  import ipf_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output div_stat_t         stat
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  dvd;
  logic [W-1:0]  dvs;
  logic [W-1:0]  rem;
  logic [W-1:0]  quot;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] rem_next;

  assign trial    = {rem, dvd[W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = (trial >= {1'b0, dvs});
  assign rem_next = fits ? diff[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      quot <= '0;
      cnt  <= CW'(W - 1);
    end else if (busy) begin
      dvd  <= {dvd[W-2:0], 1'b0};
      rem  <= rem_next;
      quot <= {quot[W-2:0], fits};
      cnt  <= cnt - CW'(1);
    end
  end

  assign stat.done       = done;
  assign stat.rem_zero   = (rem == '0);
  assign stat.quot_below = (quot < dvs);

endmodule
`default_nettype wire

/* rtl/core/interval_prime_finder_unit.sv */
// Interval prime finder: top level with sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
// Takes one interval [low_bound, high_bound] per transaction and returns every
// prime in it in rising order (kind 0), then one closing result (kind 1) with
// last set. An interval with high_bound not above low_bound gives a single
// kind 2 result, one holding more than MAX_SPAN numbers a single kind 3
// result. Bounds are cut to their low VALUE_BITS bits (at most 32). Each odd
// candidate n >= 5 is tried against divisors 3, 5, 7, ... up to its square
// root, each divisor a full W-bit division in the bit-serial divider
// (W = min(VALUE_BITS, 32)). Even numbers and values below 2 pass S_TEST and
// S_ADVANCE only, 2 and 3 also S_PUSH_PRIME, which waits out any output
// stall. Input is taken only while no interval is in work; the output
// register lets the next interval in while the last result still waits.
module interval_prime_finder_unit
  import ipf_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_SPAN   = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

`include "interval_prime_finder_unit_assert.svh"

  localparam int W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  ipf_state_t state;
  ipf_state_t state_next;

  logic [W-1:0] n;
  logic [W-1:0] hi;
  logic [W-1:0] d;
  kind_t        last_kind;

  logic [W-1:0] lo_in;
  logic [W-1:0] hi_in;
  logic [W-1:0] span_in;
  logic         bad_order;
  logic         too_wide;
  logic         accept;
  logic         out_free;

  logic         div_start;
  logic [W-1:0] div_dvs;
  logic         load_prime;
  logic         load_last;
  div_stat_t    div_stat;

  assign lo_in     = in_data.low_bound[W-1:0];
  assign hi_in     = in_data.high_bound[W-1:0];
  assign span_in   = hi_in - lo_in;
  assign bad_order = (hi_in <= lo_in);
  assign too_wide  = (span_in >= W'(MAX_SPAN));
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  ipf_serial_div #(
    .W(W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(n),
    .divisor (div_dvs),
    .stat    (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (bad_order || too_wide) ? S_PUSH_LAST : S_TEST;
        end
      end
      S_TEST: begin
        if (n < W'(2)) begin
          state_next = S_ADVANCE;
        end else if (n < W'(4)) begin
          state_next = S_PUSH_PRIME;
        end else if (!n[0]) begin
          state_next = S_ADVANCE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (div_stat.quot_below) begin
            state_next = S_PUSH_PRIME;
          end else if (div_stat.rem_zero) begin
            state_next = S_ADVANCE;
          end
        end
      end
      S_ADVANCE: begin
        state_next = (n == hi) ? S_PUSH_LAST : S_TEST;
      end
      S_PUSH_PRIME: begin
        if (out_free) begin
          state_next = S_ADVANCE;
        end
      end
      S_PUSH_LAST: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_start  = 1'b0;
    div_dvs    = d + W'(2);
    load_prime = 1'b0;
    load_last  = 1'b0;
    unique case (state)
      S_TEST: begin
        div_dvs   = W'(3);
        div_start = (n >= W'(4)) && n[0];
      end
      S_DIV: begin
        div_start = div_stat.done && !div_stat.quot_below && !div_stat.rem_zero;
      end
      S_PUSH_PRIME: load_prime = out_free;
      S_PUSH_LAST:  load_last  = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n  <= lo_in;
      hi <= hi_in;
      if (bad_order) begin
        last_kind <= KIND_WRONG;
      end else if (too_wide) begin
        last_kind <= KIND_SPAN;
      end else begin
        last_kind <= KIND_DONE;
      end
    end else if (state == S_ADVANCE && n != hi) begin
      n <= n + W'(1);
    end
    if (div_start) begin
      d <= div_dvs;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_prime || load_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_prime) begin
      out_data.prime_value <= VALUE_W'(n);
      out_data.kind        <= KIND_PRIME;
      out_data.last        <= 1'b0;
    end else if (load_last) begin
      out_data.prime_value <= '0;
      out_data.kind        <= last_kind;
      out_data.last        <= 1'b1;
    end
  end

  `IPF_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall)
  `IPF_ASSERT_HOLDS(a_last_on_close, clk, rst,
    !out_valid || (out_data.last == (out_data.kind != KIND_PRIME)))
  `IPF_ASSERT_HOLDS(a_zero_value_on_close, clk, rst,
    !out_valid || out_data.kind == KIND_PRIME || out_data.prime_value == '0)
  `IPF_ASSERT_HOLDS(a_div_only_in_test, clk, rst,
    !div_start || state == S_TEST || state == S_DIV)

endmodule
`default_nettype wire
